>>> sv/weighted_pool_sampler_defines.svh
// Assertion macros shared by the weighted pool sampler RTL.
`ifndef WEIGHTED_POOL_SAMPLER_DEFINES_SVH
`define WEIGHTED_POOL_SAMPLER_DEFINES_SVH

// Check a same-cycle implication on the block clock, off during reset.
`define WPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on the block clock, off during reset.
`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wps_pkg.sv
// Shared types and constants for the weighted pool sampler.
package wps_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned TOTAL_W         = 40;
  localparam int unsigned OPEN_W          = 48;
  localparam int unsigned SUM_W           = 50;
  localparam int unsigned INDEX_OUT_W     = 8;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_BEGIN = 3'd1,
    OP_TERM  = 3'd2,
    OP_CLOSE = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_CLOSE,
    ST_SEARCH,
    ST_RESP
  } state_t;

endpackage

>>> sv/weighted_pool_sampler.sv
// Weighted pool sampler top level: entry builder, prefix table and search sequencer.
//
//  channel | dir | handshake              | content
//  in_     | in  | in_tvalid / in_tready  | tuser opcode, tdata weights and position
//  out_    | out | out_tvalid / out_tready| tdata entry index, tuser status flags
//
// Clear, begin and a close into a full table finish when accepted; add term and close
// go on through the TERM or CLOSE state, sharing one 50-bit adder (term also uses the
// 32x32 multiplier when accepted). A query finds its entry by binary search over the
// entries, one read and compare per step, then passes through the output register.
// Synchronous reset (rst_n low) empties the table; in_tready is low while an item is in
// work; a waiting result blocks only a finished query, held until the output is free.
`include "weighted_pool_sampler_defines.svh"

module weighted_pool_sampler #(
  parameter int unsigned MAX_ENTRIES = wps_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // base_weight[31:0], influence_value[63:32],
                                  // influence_factor[95:64], position[135:96]
  input  logic [2:0]   in_tuser,  // opcode[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata, // entry_index[7:0]
  output logic [1:0]   out_tuser  // status[0], overflowed[1]
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW = wps_pkg::TOTAL_W;
  localparam int unsigned OW = wps_pkg::OPEN_W;
  localparam int unsigned SW = wps_pkg::SUM_W;
  localparam int unsigned XW = wps_pkg::INDEX_OUT_W;

  // Input field views
  logic [2:0]        op;
  logic [31:0]       base_w;
  logic [31:0]       infl_val;
  logic [31:0]       infl_fac;
  logic [TW-1:0]     pos_in;

  assign op       = in_tuser[2:0];
  assign base_w   = in_tdata[31:0];
  assign infl_val = in_tdata[63:32];
  assign infl_fac = in_tdata[95:64];
  assign pos_in   = in_tdata[135:96];

  // Control state
  wps_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic [OW-1:0]   open_r, open_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [63:0] prod_r, prod_nxt;
  logic [TW-1:0]      pos_r, pos_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;
  logic [IW-1:0]      hi_r, hi_nxt;
  logic [IW-1:0]      mid_r, mid_nxt;
  logic [XW-1:0]      res_idx_r, res_idx_nxt;
  logic               res_status_r, res_status_nxt;
  logic [XW-1:0]      out_idx_r, out_idx_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // Memory port signals
  logic          wr_en;
  logic [IW-1:0] rd_addr;
  logic [TW-1:0] rd_data;

  // Shared adder signals
  logic [SW-1:0] add_a, add_b, add_sum;
  logic [OW-1:0] open_sat;
  logic [TW-1:0] total_sat;
  logic          open_pos;

  // Search helpers
  logic          in_fire;
  logic          full;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_half;
  logic [IW-1:0] lo_step, hi_step, diff_step;
  logic [IW+XW-1:0] idx_ext;
  logic          out_free;

  // Check helpers
  logic          chk_search_ok;
  logic          chk_empty_query;
  logic          chk_resp_empty;
  logic          chk_full_close;

  assign in_fire  = in_tvalid && in_tready;
  assign full     = (count_r >= CW'(MAX_ENTRIES));
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_half = cnt_m1 >> 1;
  assign open_pos = !open_r[OW-1] && (open_r != '0);
  assign out_free = !out_valid_r || out_tready;

  // Select adder operands: term accumulate or close into running total
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_r)
      wps_pkg::ST_TERM: begin
        add_a = {{(SW-OW){open_r[OW-1]}}, open_r};
        add_b = {{(SW-OW){prod_r[63]}}, prod_r[63:16]};
      end
      wps_pkg::ST_CLOSE: begin
        add_a = {{(SW-TW){1'b0}}, total_r};
        add_b = open_pos ? {{(SW-OW){1'b0}}, open_r} : '0;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // Saturate to the open weight range and to the total range
  always_comb begin
    if (add_sum[SW-1:OW-1] == '0 || add_sum[SW-1:OW-1] == '1) begin
      open_sat = add_sum[OW-1:0];
    end else if (add_sum[SW-1]) begin
      open_sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      open_sat = {1'b0, {(OW-1){1'b1}}};
    end
    total_sat = (add_sum[SW-1:TW] != '0) ? '1 : add_sum[TW-1:0];
  end

  // One binary search step on the registered table word
  always_comb begin
    lo_step = lo_r;
    hi_step = hi_r;
    if (rd_data < pos_r) begin
      lo_step = mid_r + IW'(1);
    end else begin
      hi_step = mid_r;
    end
    diff_step = hi_step - lo_step;
  end

  // Sequencer: next state, datapath updates and memory control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    open_nxt       = open_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    prod_nxt       = prod_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    out_ovf_nxt    = out_ovf_r;
    wr_en          = 1'b0;
    rd_addr        = mid_r;
    idx_ext        = '0;

    case (state_r)
      wps_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (op)
            wps_pkg::OP_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
              open_nxt  = '0;
              ovf_nxt   = 1'b0;
            end
            wps_pkg::OP_BEGIN: begin
              open_nxt = {{(OW-32){base_w[31]}}, base_w};
            end
            wps_pkg::OP_TERM: begin
              prod_nxt  = $signed(infl_val) * $signed(infl_fac);
              state_nxt = wps_pkg::ST_TERM;
            end
            wps_pkg::OP_CLOSE: begin
              if (full) begin
                ovf_nxt  = 1'b1;
                open_nxt = '0;
              end else begin
                state_nxt = wps_pkg::ST_CLOSE;
              end
            end
            wps_pkg::OP_QUERY: begin
              pos_nxt = pos_in;
              lo_nxt  = '0;
              hi_nxt  = cnt_m1[IW-1:0];
              mid_nxt = cnt_half[IW-1:0];
              rd_addr = cnt_half[IW-1:0];
              if (count_r == '0) begin
                res_idx_nxt    = '0;
                res_status_nxt = 1'b1;
                state_nxt      = wps_pkg::ST_RESP;
              end else if (count_r == CW'(1)) begin
                res_idx_nxt    = '0;
                res_status_nxt = 1'b0;
                state_nxt      = wps_pkg::ST_RESP;
              end else begin
                state_nxt = wps_pkg::ST_SEARCH;
              end
            end
            default: begin
              state_nxt = wps_pkg::ST_IDLE;
            end
          endcase
        end
      end

      wps_pkg::ST_TERM: begin
        open_nxt  = open_sat;
        state_nxt = wps_pkg::ST_IDLE;
      end

      wps_pkg::ST_CLOSE: begin
        total_nxt = total_sat;
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        open_nxt  = '0;
        state_nxt = wps_pkg::ST_IDLE;
      end

      wps_pkg::ST_SEARCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt = lo_step + (diff_step >> 1);
          rd_addr = lo_step + (diff_step >> 1);
        end else begin
          idx_ext        = {{XW{1'b0}}, lo_step};
          res_idx_nxt    = idx_ext[XW-1:0];
          res_status_nxt = 1'b0;
          state_nxt      = wps_pkg::ST_RESP;
        end
      end

      wps_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_status_nxt = res_status_r;
          out_ovf_nxt    = ovf_r;
          state_nxt      = wps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wps_pkg::ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      open_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      open_r      <= open_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  // Prefix table
  wps_prefix_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (total_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Drive ports
  assign in_tready  = (state_r == wps_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = {out_ovf_r, out_status_r};

  // Checks
  assign chk_search_ok   = (state_r != wps_pkg::ST_SEARCH) ||
                           ((lo_r <= mid_r) && (mid_r < hi_r) &&
                            ({1'b0, hi_r} < {1'b0, count_r}));
  assign chk_empty_query = in_fire && (op == wps_pkg::OP_QUERY) && (count_r == '0);
  assign chk_resp_empty  = (state_r == wps_pkg::ST_RESP) && res_status_r;
  assign chk_full_close  = in_fire && (op == wps_pkg::OP_CLOSE) && full;

  `WPS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_ENTRIES), "entry count past depth")
  `WPS_ASSERT_NOW(a_search_range, 1'b1, chk_search_ok, "search interval outside table")
  `WPS_ASSERT_NEXT(a_empty_query, chk_empty_query, chk_resp_empty, "empty query not flagged")
  `WPS_ASSERT_NEXT(a_full_close, chk_full_close, ovf_r && $stable(count_r), "full close kept")

endmodule

>>> sv/wps_prefix_mem.sv
// Prefix-sum table: one write port, one registered read port.
module wps_prefix_mem #(
  parameter int unsigned DEPTH = wps_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(wps_pkg::MAX_ENTRIES_DEF)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [wps_pkg::TOTAL_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [wps_pkg::TOTAL_W-1:0] rd_data
);

  logic [wps_pkg::TOTAL_W-1:0] mem [DEPTH];
  logic [wps_pkg::TOTAL_W-1:0] rd_data_r;

  // Write one cumulative total per close
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle into the output register
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/sv/weighted_pool_sampler_tb.sv
// Self-checking testbench for the weighted pool sampler: directed and random words.
`timescale 1ns / 100ps

module weighted_pool_sampler_tb;

  localparam int          CLK_PERIOD   = 8;
  localparam int          RESET_CYCLES = 6;
  localparam int          RANDOM_WORDS = 750;
  localparam int          FILL_AT      = 300;
  localparam int          TAIL_CYCLES  = 40;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          REPORT_LIMIT = 10;
  localparam int unsigned TABLE_DEPTH  = wps_pkg::MAX_ENTRIES_DEF;

  localparam logic signed [63:0] OPEN_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OPEN_LO   = 64'shFFFF_8000_0000_0000;
  localparam logic        [63:0] TOTAL_CAP = 64'h0000_00FF_FFFF_FFFF;

  // One input word as the sender sees it
  typedef struct {
    logic [2:0]         opcode;
    logic signed [31:0] base_weight;
    logic signed [31:0] infl_value;
    logic signed [31:0] infl_factor;
    logic [39:0]        position;
    bit                 hold_for_drain;
  } pool_word_t;

  // One selection result
  typedef struct packed {
    logic [7:0] entry_index;
    logic       status;
    logic       overflowed;
  } pick_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;  // base_weight[31:0], influence_value[63:32],
                                  // influence_factor[95:64], position[135:96]
  logic [2:0]   in_tuser   = '0;  // opcode[2:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;        // entry_index[7:0]
  logic [1:0]   out_tuser;        // status[0], overflowed[1]

  pool_word_t pending_words[$];
  pick_t      owed_picks[$];
  int         live_words  = 0;
  int         err_count   = 0;
  int         quiet_cycles = 0;
  int         calm_left   = 0;
  int         send_gap    = 0;
  int         recv_gap    = 0;
  logic       drained     = 1'b1;

  // Predicted pool state
  logic [39:0]        pool_prefix [TABLE_DEPTH];
  int unsigned        pool_count = 0;
  logic [39:0]        pool_total = '0;
  logic signed [47:0] open_wt    = '0;
  logic               ovf_seen   = 1'b0;

  weighted_pool_sampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the pool state by one word; return 1 when a selection comes out
  function automatic bit predict_pick(input pool_word_t w, output pick_t res);
    logic signed [63:0] prod;
    logic signed [63:0] acc;
    logic [63:0]        grown;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        mid;
    res = '0;
    case (w.opcode)
      wps_pkg::OP_CLEAR: begin
        pool_count = 0;
        pool_total = '0;
        open_wt    = '0;
        ovf_seen   = 1'b0;
      end
      wps_pkg::OP_BEGIN: begin
        open_wt = w.base_weight;
      end
      wps_pkg::OP_TERM: begin
        // exact Q32.32 product, floored to Q32.16, then saturated
        prod = w.infl_value * w.infl_factor;
        acc  = open_wt + (prod >>> 16);
        if (acc > OPEN_HI) acc = OPEN_HI;
        if (acc < OPEN_LO) acc = OPEN_LO;
        open_wt = acc[47:0];
      end
      wps_pkg::OP_CLOSE: begin
        if (pool_count >= TABLE_DEPTH) begin
          ovf_seen = 1'b1;
        end else begin
          if (open_wt > 0) begin
            grown      = 64'(pool_total) + 64'(open_wt);
            pool_total = (grown > TOTAL_CAP) ? TOTAL_CAP[39:0] : grown[39:0];
          end
          pool_prefix[pool_count] = pool_total;
          pool_count++;
        end
        open_wt = '0;
      end
      wps_pkg::OP_QUERY: begin
        if (pool_count == 0) begin
          res.status = 1'b1;
        end else begin
          // first entry whose running total reaches the position
          lo = 0;
          hi = pool_count - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (pool_prefix[mid] < w.position) lo = mid + 1;
            else hi = mid;
          end
          res.entry_index = lo[7:0];
        end
        res.overflowed = ovf_seen;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Idle length: mostly none or short, a few long, none during a calm stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [31:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 16 << 16);
    if (r < 95) return -int'($urandom_range(0, 16 << 16));
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_term();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return int'($urandom_range(0, 8 << 16)) - (4 << 16);
  endfunction

  function automatic logic [39:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 55) return 40'({$urandom, $urandom});
    return 40'($urandom_range(0, 1 << $urandom_range(8, 26)));
  endfunction

  // Queue one word; fields the opcode does not use stay random
  task automatic push(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b,
                      input logic [39:0] pos);
    pool_word_t w;
    w.opcode         = op;
    w.base_weight    = $urandom;
    w.infl_value     = $urandom;
    w.infl_factor    = $urandom;
    w.position       = 40'({$urandom, $urandom});
    w.hold_for_drain = 1'b0;
    case (op)
      wps_pkg::OP_BEGIN: w.base_weight = a;
      wps_pkg::OP_TERM: begin
        w.infl_value  = a;
        w.infl_factor = b;
      end
      wps_pkg::OP_QUERY: w.position = pos;
      default: ;
    endcase
    if (op <= wps_pkg::OP_QUERY) live_words++;
    pending_words.push_back(w);
  endtask

  task automatic flag_error(input string what, input pick_t want, input pick_t got);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("%0t: %s: expected index/status/overflowed %0d/%0d/%0d, got %0d/%0d/%0d",
               $realtime, what, want.entry_index, want.status, want.overflowed,
               got.entry_index, got.status, got.overflowed);
  endtask

  // Calm stretches in which neither side picks a new idle gap
  always @(posedge clk) begin
    if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 299) == 0) calm_left <= $urandom_range(40, 120);
  end

  // Driver: present queued words, idle between them, hold for a drain when marked
  always @(posedge clk) begin : drive_words
    logic next_valid;
    logic took;
    pool_word_t w;
    took = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        void'(pending_words.pop_front());
        send_gap   = pick_gap();
        next_valid = 1'b0;
        took       = 1'b1;
      end
      if (!next_valid && pending_words.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!pending_words[0].hold_for_drain || (drained && !took)) begin
          w = pending_words[0];
          in_tdata   <= {w.position, w.infl_factor, w.infl_value, w.base_weight};
          in_tuser   <= w.opcode;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Monitor: predict on accepted input words, check accepted results, stall the output
  always @(posedge clk) begin : check_words
    pool_word_t seen;
    pick_t want;
    pick_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        seen.opcode         = in_tuser;
        seen.base_weight    = in_tdata[31:0];
        seen.infl_value     = in_tdata[63:32];
        seen.infl_factor    = in_tdata[95:64];
        seen.position       = in_tdata[135:96];
        seen.hold_for_drain = 1'b0;
        if (predict_pick(seen, want)) owed_picks.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.entry_index = out_tdata;
        got.status      = out_tuser[0];
        got.overflowed  = out_tuser[1];
        if (owed_picks.size() == 0) begin
          flag_error("result with nothing expected", '0, got);
        end else begin
          want = owed_picks.pop_front();
          if (got !== want) flag_error("result mismatch", want, got);
        end
      end
      drained <= (owed_picks.size() == 0);
      if (recv_gap == 0 && $urandom_range(0, 99) < 20) recv_gap = pick_gap();
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Count cycles in which neither side moves a word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("weighted_pool_sampler regression: fail");
    $finish;
  end

  // Build the stimulus, release reset, wait for the drain and report
  initial begin : stimulus
    int  r;
    int  n;
    bit  fill_done;
    fill_done = 1'b0;

    // empty table, zero-weight and negative entries, a plain entry
    push(wps_pkg::OP_QUERY, '0, '0, pick_position());
    push(wps_pkg::OP_CLOSE, '0, '0, '0);
    push(wps_pkg::OP_TERM, 32'hFFFF_FFFF, 32'h0000_0001, '0);
    push(wps_pkg::OP_CLOSE, '0, '0, '0);
    push(wps_pkg::OP_BEGIN, 32'h0003_0000, '0, '0);
    push(wps_pkg::OP_TERM, 32'h0000_8000, 32'h0002_0000, '0);
    push(wps_pkg::OP_CLOSE, '0, '0, '0);
    // position on, above and below the total
    push(wps_pkg::OP_QUERY, '0, '0, 40'h4_0000);
    push(wps_pkg::OP_QUERY, '0, '0, 40'h4_0001);
    push(wps_pkg::OP_QUERY, '0, '0, 40'd1);
    push(wps_pkg::OP_QUERY, '0, '0, 40'd0);
    // open weight saturating low, then high, the total saturating
    push(wps_pkg::OP_BEGIN, 32'h8000_0000, '0, '0);
    push(wps_pkg::OP_TERM, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    push(wps_pkg::OP_TERM, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    push(wps_pkg::OP_CLOSE, '0, '0, '0);
    push(wps_pkg::OP_BEGIN, 32'h7FFF_FFFF, '0, '0);
    push(wps_pkg::OP_TERM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    push(wps_pkg::OP_TERM, 32'h8000_0000, 32'h8000_0000, '0);
    push(wps_pkg::OP_CLOSE, '0, '0, '0);
    push(wps_pkg::OP_QUERY, '0, '0, 40'hFF_FFFF_FFFF);
    // unused opcodes, then clear back to empty
    push(3'd5, '0, '0, '0);
    push(3'd6, '0, '0, '0);
    push(3'd7, '0, '0, '0);
    push(wps_pkg::OP_CLEAR, '0, '0, '0);
    push(wps_pkg::OP_QUERY, '0, '0, pick_position());

    live_words = 0;
    pending_words[pending_words.size() - 1].hold_for_drain = 1'b1;

    while (live_words < RANDOM_WORDS) begin
      if (!fill_done && live_words >= FILL_AT) begin
        // fill the table past its depth, probing along the way
        fill_done = 1'b1;
        push(wps_pkg::OP_CLEAR, '0, '0, '0);
        pending_words[pending_words.size() - 1].hold_for_drain = 1'b1;
        for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
          if (i % 9 == 0) push(wps_pkg::OP_BEGIN, $urandom_range(1, 8 << 16), '0, '0);
          push(wps_pkg::OP_CLOSE, '0, '0, '0);
          if (i % 23 == 0 || i >= TABLE_DEPTH - 2)
            push(wps_pkg::OP_QUERY, '0, '0, pick_position());
        end
        push(wps_pkg::OP_QUERY, '0, '0, 40'hFF_FFFF_FFFF);
        push(wps_pkg::OP_CLEAR, '0, '0, '0);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push(wps_pkg::OP_BEGIN, pick_weight(), '0, '0);
        n = $urandom_range(0, 3);
        repeat (n) push(wps_pkg::OP_TERM, pick_term(), pick_term(), '0);
        push(wps_pkg::OP_CLOSE, '0, '0, '0);
      end else if (r < 80) begin
        push(wps_pkg::OP_QUERY, '0, '0, pick_position());
        if ($urandom_range(0, 49) == 0)
          pending_words[pending_words.size() - 1].hold_for_drain = 1'b1;
      end else if (r < 83) begin
        push(wps_pkg::OP_CLEAR, '0, '0, '0);
      end else if (r < 88) begin
        push(wps_pkg::OP_TERM, pick_term(), pick_term(), '0);
      end else if (r < 92) begin
        push(wps_pkg::OP_CLOSE, '0, '0, '0);
      end else if (r < 95) begin
        push(wps_pkg::OP_BEGIN, pick_weight(), '0, '0);
      end else begin
        push(3'($urandom_range(5, 7)), '0, '0, '0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0);
    wait (owed_picks.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0 && owed_picks.size() == 0) begin
      $display("weighted_pool_sampler regression: pass");
    end else begin
      $display("weighted_pool_sampler regression: fail");
    end
    $finish;
  end

endmodule

>>> weighted_pool_sampler.f
+incdir+sv
sv/wps_pkg.sv
sv/wps_prefix_mem.sv
sv/weighted_pool_sampler.sv
tb/sv/weighted_pool_sampler_tb.sv
